### design/isd_pkg.sv
`timescale 1ns / 1ps

package isd_pkg;

    // Field widths of the channels
    localparam int BYTE_W   = 8;
    localparam int IDX_W    = 13;
    localparam int VAL_W    = 32;
    localparam int WAIT_W   = 16;
    localparam int CFG_IX_W = 2;
    localparam int CFG_D_W  = 13;

    // Command codes handed to the executor
    typedef enum logic [3:0] {
        CMD_WR_IDX   = 4'd0,
        CMD_WR_DIR   = 4'd1,
        CMD_MASK_IDX = 4'd2,
        CMD_MASK_DIR = 4'd3,
        CMD_DELAY    = 4'd4,
        CMD_WAIT_MC  = 4'd5,
        CMD_WAIT_MEM = 4'd6,
        CMD_PLL_WR   = 4'd7,
        CMD_PLL_MASK = 4'd8,
        CMD_WAIT_DLL = 4'd9,
        CMD_POWER    = 4'd10,
        CMD_SDRAM    = 4'd11,
        CMD_NONE     = 4'd12
    } t_cmd;

    typedef enum logic [1:0] {
        ST_CMD  = 2'd0,
        ST_DONE = 2'd1,
        ST_ERR  = 2'd2
    } t_status;

    // Outcome of decoding one byte
    typedef enum logic [1:0] {
        OC_MORE,
        OC_CMD,
        OC_DONE,
        OC_ERR
    } t_outcome;

    // Position inside the current entry
    typedef enum logic [1:0] {
        PH_HDR0,
        PH_HDR1,
        PH_BODY
    } t_phase;

    // Script formats
    localparam logic [1:0] FMT_INIT  = 2'd0;
    localparam logic [1:0] FMT_PLL   = 2'd1;
    localparam logic [1:0] FMT_SDRAM = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IX_W-1:0] CFG_FORMAT = 2'd0;
    localparam logic [CFG_IX_W-1:0] CFG_LIMIT  = 2'd1;

    // Register init header flags (top three bits)
    localparam logic [2:0] FLG_WR_IDX   = 3'd0;
    localparam logic [2:0] FLG_WR_DIR   = 3'd1;
    localparam logic [2:0] FLG_MASK_IDX = 3'd2;
    localparam logic [2:0] FLG_MASK_DIR = 3'd3;
    localparam logic [2:0] FLG_DELAY    = 3'd4;
    localparam logic [2:0] FLG_SPECIAL  = 3'd5;
    localparam logic [2:0] FLG_BAD_LO   = 3'd6;
    localparam logic [7:0] SPC_MC_IDLE  = 8'h03;
    localparam logic [7:0] SPC_MEM      = 8'h08;

    // PLL header flags and fixed wait codes
    localparam logic [1:0] PLL_WR    = 2'b00;
    localparam logic [1:0] PLL_MASK  = 2'b01;
    localparam logic [1:0] PLL_FIXED = 2'b10;
    localparam logic [5:0] PW_DLY_SHORT = 6'd1;
    localparam logic [5:0] PW_DLY_LONG  = 6'd2;
    localparam logic [5:0] PW_MC_IDLE   = 6'd3;
    localparam logic [5:0] PW_DLL       = 6'd4;
    localparam logic [5:0] PW_POWER     = 6'd5;
    localparam logic [7:0] PLL_END      = 8'h00;
    localparam logic [7:0] PLL_MAX_LANE = 8'h03;

    // SDRAM reset script codes
    localparam logic [7:0] SDR_END  = 8'hff;
    localparam logic [7:0] SDR_WAIT = 8'h0f;

    // Fixed wait values
    localparam logic [WAIT_W-1:0] WT_SHORT_US = 16'd150;
    localparam logic [WAIT_W-1:0] WT_LONG_US  = 16'd5000;
    localparam logic [WAIT_W-1:0] WT_POLL     = 16'd1000;
    localparam logic [WAIT_W-1:0] WT_SDR_POLL = 16'd20000;

    // One result item
    typedef struct packed {
        t_cmd              command;
        logic [IDX_W-1:0]  reg_index;
        logic [VAL_W-1:0]  value_a;
        logic [VAL_W-1:0]  value_b;
        logic [WAIT_W-1:0] wait_count;
        t_status           status;
    } t_result;

    localparam t_result RES_ERR = '{
        command:    CMD_NONE,
        reg_index:  '0,
        value_a:    '0,
        value_b:    '0,
        wait_count: '0,
        status:     ST_ERR
    };

    // Configuration write as seen by the decoder
    typedef struct packed {
        logic                en;
        logic [CFG_IX_W-1:0] index;
        logic [CFG_D_W-1:0]  data;
    } t_cfg_wr;

    // Result pushes from the decoder into the output queue
    typedef struct packed {
        logic    first;
        logic    second;
        t_result res;
    } t_push;

endpackage

### design/isd_if.sv
`timescale 1ns / 1ps

// Script byte channel
interface isd_in_if import isd_pkg::*; ;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] script_byte;
    logic              starts_script;
    logic              image_end;

    modport source (output valid, script_byte, starts_script, image_end, input ready);
    modport sink   (input valid, script_byte, starts_script, image_end, output ready);
endinterface

// Command result channel
interface isd_out_if import isd_pkg::*; ;
    logic              valid;
    logic              ready;
    logic [3:0]        command;
    logic [IDX_W-1:0]  reg_index;
    logic [VAL_W-1:0]  value_a;
    logic [VAL_W-1:0]  value_b;
    logic [WAIT_W-1:0] wait_count;
    logic [1:0]        status;

    modport source (output valid, command, reg_index, value_a, value_b, wait_count,
                    status, input ready);
    modport sink   (input valid, command, reg_index, value_a, value_b, wait_count,
                    status, output ready);
endinterface

// Configuration write channel
interface isd_cfg_if import isd_pkg::*; ;
    logic                valid;
    logic                ready;
    logic [CFG_IX_W-1:0] index;
    logic [CFG_D_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### design/isd_dec.sv
`timescale 1ns / 1ps

// Byte-wise entry decoder: field collector, header checks and entry counting
module isd_dec import isd_pkg::*; #(
    parameter int MAX_ENTRIES = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [BYTE_W-1:0] i_script_byte,
    input  logic              i_starts_script,
    input  logic              i_image_end,
    input  t_cfg_wr           i_cfg,
    output t_push             o_push
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);

    logic [1:0]         r_fmt, n_fmt;
    logic [CFG_D_W-1:0] r_limit, n_limit;
    t_phase             r_phase, n_phase;
    logic [15:0]        r_hdr, n_hdr;
    logic [63:0]        r_pay, n_pay;
    logic [2:0]         r_cnt, n_cnt;
    logic [CW-1:0]      r_seen, n_seen;
    logic               r_fin, n_fin;

    // state as seen by this byte, after a script start clears it
    t_phase        ph;
    logic [15:0]   hdr;
    logic [63:0]   pay;
    logic [2:0]    cnt;
    logic [CW-1:0] seen;
    logic          fin;

    assign ph   = i_starts_script ? PH_HDR0 : r_phase;
    assign hdr  = i_starts_script ? 16'h0000 : r_hdr;
    assign pay  = i_starts_script ? 64'h0 : r_pay;
    assign cnt  = i_starts_script ? 3'd0 : r_cnt;
    assign seen = i_starts_script ? '0 : r_seen;
    assign fin  = i_starts_script ? 1'b0 : r_fin;

    // payload with this byte dropped into its lane
    logic [63:0] pay_n;
    logic [3:0]  n_bytes;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            pay_n[8*i +: 8] = (cnt == 3'(i)) ? i_script_byte : pay[8*i +: 8];
        end
    end

    assign n_bytes = {1'b0, cnt} + 4'd1;

    // decode of one byte
    t_outcome    oc;
    t_cmd        d_cmd;
    logic [IDX_W-1:0]  d_idx;
    logic [VAL_W-1:0]  d_a, d_b;
    logic [WAIT_W-1:0] d_wait;
    t_phase      ph_d;
    logic [15:0] hdr_d;
    logic        col;
    logic [15:0] hw;
    logic [2:0]  flag;
    logic [3:0]  need;
    logic [4:0]  sh;

    always_comb begin
        oc     = OC_MORE;
        d_cmd  = CMD_NONE;
        d_idx  = '0;
        d_a    = '0;
        d_b    = '0;
        d_wait = '0;
        ph_d   = ph;
        hdr_d  = hdr;
        col    = 1'b0;
        hw     = {i_script_byte, hdr[7:0]};
        flag   = hdr[15:13];
        need   = 4'd2;
        sh     = {pay_n[1:0], 3'b000};

        case (r_fmt)
            FMT_INIT: begin
                case (ph)
                    PH_HDR0: begin
                        hdr_d = {8'h00, i_script_byte};
                        ph_d  = PH_HDR1;
                    end
                    PH_HDR1: begin
                        hdr_d = hw;
                        if (hw == 16'h0000) begin
                            oc = OC_DONE;
                        end else if (hw[15:13] >= FLG_BAD_LO) begin
                            oc = OC_ERR;
                        end else if (hw[15:13] == FLG_SPECIAL && hw[7:0] != SPC_MC_IDLE
                                     && hw[7:0] != SPC_MEM) begin
                            oc = OC_ERR;
                        end else begin
                            ph_d = PH_BODY;
                        end
                    end
                    default: begin
                        col = 1'b1;
                        if (flag <= FLG_WR_DIR) begin
                            need = 4'd4;
                        end else if (flag <= FLG_MASK_DIR) begin
                            need = 4'd8;
                        end else begin
                            need = 4'd2;
                        end
                        if (n_bytes >= need) begin
                            oc = OC_CMD;
                            case (flag)
                                FLG_WR_IDX: begin
                                    d_cmd = CMD_WR_IDX;
                                    d_idx = hdr[12:0];
                                    d_a   = pay_n[31:0];
                                end
                                FLG_WR_DIR: begin
                                    d_cmd = CMD_WR_DIR;
                                    d_idx = hdr[12:0];
                                    d_a   = pay_n[31:0];
                                end
                                FLG_MASK_IDX: begin
                                    d_cmd = CMD_MASK_IDX;
                                    d_idx = hdr[12:0];
                                    d_a   = pay_n[31:0];
                                    d_b   = pay_n[63:32];
                                end
                                FLG_MASK_DIR: begin
                                    d_cmd = CMD_MASK_DIR;
                                    d_idx = hdr[12:0];
                                    d_a   = ~pay_n[31:0];
                                    d_b   = pay_n[63:32];
                                end
                                FLG_DELAY: begin
                                    d_cmd  = CMD_DELAY;
                                    d_wait = pay_n[15:0];
                                end
                                default: begin
                                    d_cmd  = (hdr[7:0] == SPC_MC_IDLE) ? CMD_WAIT_MC
                                                                       : CMD_WAIT_MEM;
                                    d_wait = pay_n[15:0];
                                end
                            endcase
                        end
                    end
                endcase
            end
            FMT_PLL: begin
                if (ph == PH_HDR0) begin
                    hdr_d = {8'h00, i_script_byte};
                    if (i_script_byte == PLL_END) begin
                        oc = OC_DONE;
                    end else if (i_script_byte[7:6] == PLL_FIXED) begin
                        oc = OC_CMD;
                        case (i_script_byte[5:0])
                            PW_DLY_SHORT: begin
                                d_cmd  = CMD_DELAY;
                                d_wait = WT_SHORT_US;
                            end
                            PW_DLY_LONG: begin
                                d_cmd  = CMD_DELAY;
                                d_wait = WT_LONG_US;
                            end
                            PW_MC_IDLE: begin
                                d_cmd  = CMD_WAIT_MC;
                                d_wait = WT_POLL;
                            end
                            PW_DLL: begin
                                d_cmd  = CMD_WAIT_DLL;
                                d_wait = WT_POLL;
                            end
                            PW_POWER: d_cmd = CMD_POWER;
                            default:  oc = OC_ERR;
                        endcase
                    end else if (i_script_byte[7:6] != PLL_WR
                                 && i_script_byte[7:6] != PLL_MASK) begin
                        oc = OC_ERR;
                    end else begin
                        ph_d = PH_BODY;
                    end
                end else begin
                    col = 1'b1;
                    if (hdr[7:6] == PLL_WR) begin
                        if (n_bytes >= 4'd4) begin
                            oc    = OC_CMD;
                            d_cmd = CMD_PLL_WR;
                            d_idx = {7'b0, hdr[5:0]};
                            d_a   = pay_n[31:0];
                        end
                    end else if (pay_n[7:0] > PLL_MAX_LANE) begin
                        oc = OC_ERR;
                    end else if (n_bytes >= 4'd3) begin
                        // byte-lane mask: keep the other lanes, place and/or bytes
                        oc    = OC_CMD;
                        d_cmd = CMD_PLL_MASK;
                        d_idx = {7'b0, hdr[5:0]};
                        d_a   = ~(32'h0000_00ff << sh) | ({24'b0, pay_n[15:8]} << sh);
                        d_b   = {24'b0, pay_n[23:16]} << sh;
                    end
                end
            end
            FMT_SDRAM: begin
                if (ph == PH_HDR0) begin
                    hdr_d = {8'h00, i_script_byte};
                    if (i_script_byte == SDR_END) begin
                        oc = OC_DONE;
                    end else if (i_script_byte == SDR_WAIT) begin
                        oc     = OC_CMD;
                        d_cmd  = CMD_WAIT_MEM;
                        d_wait = WT_SDR_POLL;
                    end else begin
                        ph_d = PH_BODY;
                    end
                end else begin
                    col = 1'b1;
                    if (n_bytes >= 4'd2) begin
                        oc    = OC_CMD;
                        d_cmd = CMD_SDRAM;
                        d_idx = {5'b0, hdr[7:0]};
                        d_b   = {16'b0, pay_n[15:0]};
                    end
                end
            end
            default: oc = OC_ERR;
        endcase
    end

    // image end on an unfinished entry is an error
    t_outcome oc_f;
    assign oc_f = (oc == OC_MORE && i_image_end) ? OC_ERR : oc;

    // entry limit, clamped to one and to the build maximum
    logic [CFG_D_W-1:0] lim13;
    logic [CW-1:0]      lim_eff;
    logic [CW-1:0]      seen_n;
    logic               err_after;

    assign lim13   = (r_limit == '0) ? CFG_D_W'(1) : r_limit;
    assign lim_eff = (32'(lim13) > 32'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : CW'(lim13);
    assign seen_n  = seen + CW'(1);
    assign err_after = i_image_end || (seen_n >= lim_eff);

    // result items for this byte
    always_comb begin
        o_push.first  = i_accept && !fin && oc_f != OC_MORE;
        o_push.second = i_accept && !fin && oc_f == OC_CMD && err_after;
        o_push.res    = RES_ERR;
        if (oc_f == OC_CMD) begin
            o_push.res.command    = d_cmd;
            o_push.res.reg_index  = d_idx;
            o_push.res.value_a    = d_a;
            o_push.res.value_b    = d_b;
            o_push.res.wait_count = d_wait;
            o_push.res.status     = ST_CMD;
        end else if (oc_f == OC_DONE) begin
            o_push.res.status = ST_DONE;
        end
    end

    // next decoder state
    always_comb begin
        n_fmt   = r_fmt;
        n_limit = r_limit;
        n_phase = r_phase;
        n_hdr   = r_hdr;
        n_pay   = r_pay;
        n_cnt   = r_cnt;
        n_seen  = r_seen;
        n_fin   = r_fin;
        if (i_cfg.en && i_cfg.index == CFG_FORMAT) begin
            n_fmt   = i_cfg.data[1:0];
            n_phase = PH_HDR0;
            n_hdr   = '0;
            n_pay   = '0;
            n_cnt   = '0;
            n_seen  = '0;
            n_fin   = 1'b0;
        end else if (i_cfg.en && i_cfg.index == CFG_LIMIT) begin
            n_limit = i_cfg.data;
        end else if (i_accept) begin
            n_phase = ph;
            n_hdr   = hdr;
            n_pay   = pay;
            n_cnt   = cnt;
            n_seen  = seen;
            n_fin   = fin;
            if (!fin) begin
                case (oc_f)
                    OC_MORE: begin
                        n_phase = ph_d;
                        n_hdr   = hdr_d;
                        if (col) begin
                            n_pay = pay_n;
                            n_cnt = n_bytes[2:0];
                        end
                    end
                    OC_CMD: begin
                        n_phase = PH_HDR0;
                        n_hdr   = '0;
                        n_pay   = '0;
                        n_cnt   = '0;
                        n_seen  = seen_n;
                        n_fin   = err_after;
                    end
                    default: n_fin = 1'b1;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt   <= FMT_INIT;
            r_limit <= CFG_D_W'(4096);
            r_phase <= PH_HDR0;
            r_hdr   <= '0;
            r_pay   <= '0;
            r_cnt   <= '0;
            r_seen  <= '0;
            r_fin   <= 1'b0;
        end else begin
            r_fmt   <= n_fmt;
            r_limit <= n_limit;
            r_phase <= n_phase;
            r_hdr   <= n_hdr;
            r_pay   <= n_pay;
            r_cnt   <= n_cnt;
            r_seen  <= n_seen;
            r_fin   <= n_fin;
        end
    end

endmodule

### design/isd_resq.sv
`timescale 1ns / 1ps

// Four-deep result queue: up to two pushes and one pop per cycle
module isd_resq import isd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    input  logic    i_pop_ready,
    output logic    o_valid,
    output t_result o_head,
    output logic    o_room
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    t_result         r_mem [DEPTH];
    logic [AW-1:0]   r_wp, n_wp;
    logic [AW-1:0]   r_rp, n_rp;
    logic [AW:0]     r_cnt, n_cnt;
    logic            pop;
    logic [AW-1:0]   wp1;

    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rp];
    assign o_room  = (r_cnt <= (AW+1)'(DEPTH - 2));
    assign pop     = o_valid && i_pop_ready;
    assign wp1     = r_wp + AW'(1);

    // pointer and fill bookkeeping
    always_comb begin
        n_wp  = r_wp + AW'(i_push.first) + AW'(i_push.second);
        n_rp  = r_rp + AW'(pop);
        n_cnt = r_cnt + (AW+1)'(i_push.first) + (AW+1)'(i_push.second) - (AW+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // storage; the second push is always the trailing error item
    always_ff @(posedge i_clk) begin
        if (i_push.first) begin
            r_mem[r_wp] <= i_push.res;
        end
        if (i_push.second) begin
            r_mem[wp1] <= RES_ERR;
        end
    end

endmodule

### design/init_script_command_decoder_top.sv
`timescale 1ns / 1ps
// Output: the byte that completes a result item writes it into the result queue,
// from whose head it is offered. Throughput: one byte per cycle while two of the
// four-deep result queue's slots are free; the queue takes a byte only then (a byte
// gives at most two result items). Reset: synchronous active-low; format 0, entry
// limit 4096, decoder awaiting a header, result queue empty.
module init_script_command_decoder_top import isd_pkg::*; #(
    parameter int MAX_ENTRIES = 4096
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    isd_in_if.sink    i_in,
    isd_out_if.source o_out,
    isd_cfg_if.sink   i_cfg
);

    t_cfg_wr cfg_wr;
    t_push   push;
    t_result head;
    logic    room;
    logic    accept;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = room;
    assign accept      = i_in.valid && room;

    assign cfg_wr.en    = i_cfg.valid;
    assign cfg_wr.index = i_cfg.index;
    assign cfg_wr.data  = i_cfg.data;

    isd_dec #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dec (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_script_byte   (i_in.script_byte),
        .i_starts_script (i_in.starts_script),
        .i_image_end     (i_in.image_end),
        .i_cfg           (cfg_wr),
        .o_push          (push)
    );

    isd_resq u_resq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_pop_ready (o_out.ready),
        .o_valid     (o_out.valid),
        .o_head      (head),
        .o_room      (room)
    );

    // result item onto the channel
    assign o_out.command    = head.command;
    assign o_out.reg_index  = head.reg_index;
    assign o_out.value_a    = head.value_a;
    assign o_out.value_b    = head.value_b;
    assign o_out.wait_count = head.wait_count;
    assign o_out.status     = head.status;

    // a trailing error is only ever pushed together with a first item
    a_second_needs_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.second |-> push.first)
        else $error("trailing error item pushed alone");

    // a trailing error only follows an issued command
    a_second_after_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.second |-> (push.res.status == ST_CMD))
        else $error("trailing error after a finishing item");

    // once finished, bytes give nothing until a script start
    a_quiet_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.first && push.res.status != ST_CMD) ##1 (accept && !i_in.starts_script)
        |-> !push.first)
        else $error("result item after script finish");

endmodule

### tb/init_script_command_decoder_top_tb.sv
`timescale 1ns / 1ps

module init_script_command_decoder_top_tb;
    import isd_pkg::*;

    localparam int MAX_ENTRIES    = 4096;
    localparam int TIMEOUT_CYCLES = 400000;
    localparam int MAX_REPORTS    = 10;
    localparam int TAIL_CYCLES    = 4;
    localparam int RANDOM_ITEMS   = 1150;
    localparam int N_PHASES       = 12;

    // Format code the block does not define, and a register index nobody decodes
    localparam logic [1:0]          FMT_UNUSED = 2'd3;
    localparam logic [CFG_IX_W-1:0] CFG_SPARE  = 2'd3;

    localparam t_result RES_FIN = '{
        command:    CMD_NONE,
        reg_index:  '0,
        value_a:    '0,
        value_b:    '0,
        wait_count: '0,
        status:     ST_DONE
    };

    // Indexed write with every index and data bit set
    localparam t_result RES_WR_TOP = '{
        command:    CMD_WR_IDX,
        reg_index:  13'h1fff,
        value_a:    32'hffff_ffff,
        value_b:    '0,
        wait_count: '0,
        status:     ST_CMD
    };

    typedef enum logic {
        ROW_BYTE,
        ROW_FMT
    } t_row_kind;

    // One row of the directed table; a format row carries the format in sbyte
    typedef struct {
        t_row_kind  kind;
        logic [7:0] sbyte;
        logic       start;
        logic       iend;
        bit         typed;
        t_result    res;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    isd_in_if  in_if  ();
    isd_out_if out_if ();
    isd_cfg_if cfg_if ();

    init_script_command_decoder_top #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Decoder copy: configuration and per-script state
    logic [1:0]  m_fmt;
    logic [12:0] m_limit;
    t_phase      m_phase;
    logic [15:0] m_hdr;
    logic [63:0] m_pay;
    int          m_pcnt;
    int          m_seen;
    bit          m_fin;
    t_result     m_cmd;
    t_result     m_out [2];

    t_result pending_results [$];
    t_row    dir_rows [$];

    bit      cur_typed;
    t_result cur_res;

    int err_cnt;
    int results_checked;
    int live_items;
    int all_items;
    int cycles;
    int tx_idle_pct;
    int rx_idle_pct;

    function automatic void clear_entry();
        m_phase = PH_HDR0;
        m_hdr   = '0;
        m_pay   = '0;
        m_pcnt  = 0;
    endfunction

    function automatic void clear_decoder();
        clear_entry();
        m_seen = 0;
        m_fin  = 1'b0;
    endfunction

    function automatic void set_cmd(t_cmd c, logic [IDX_W-1:0] idx, logic [VAL_W-1:0] a,
                                    logic [VAL_W-1:0] b, logic [WAIT_W-1:0] w);
        m_cmd = '{command: c, reg_index: idx, value_a: a, value_b: b, wait_count: w,
                  status: ST_CMD};
    endfunction

    // Payload bytes land little-endian; only the first eight are kept
    function automatic int collect(logic [7:0] b);
        if (m_pcnt < 8) m_pay[8*m_pcnt +: 8] = b;
        m_pcnt++;
        return m_pcnt;
    endfunction

    // Register init format: 16-bit header, then 4, 8 or 2 payload bytes
    function automatic t_outcome step_init(logic [7:0] b);
        logic [2:0] flag;
        int         need;
        if (m_phase == PH_HDR0) begin
            m_hdr   = {8'h00, b};
            m_phase = PH_HDR1;
            return OC_MORE;
        end
        if (m_phase == PH_HDR1) begin
            m_hdr[15:8] = b;
            if (m_hdr == 16'h0000) return OC_DONE;
            flag = m_hdr[15:13];
            if (flag >= FLG_BAD_LO) return OC_ERR;
            if (flag == FLG_SPECIAL && m_hdr[7:0] != SPC_MC_IDLE && m_hdr[7:0] != SPC_MEM)
                return OC_ERR;
            m_phase = PH_BODY;
            return OC_MORE;
        end
        flag = m_hdr[15:13];
        need = (flag <= FLG_WR_DIR) ? 4 : ((flag <= FLG_MASK_DIR) ? 8 : 2);
        if (collect(b) < need) return OC_MORE;
        case (flag)
            FLG_WR_IDX:   set_cmd(CMD_WR_IDX, m_hdr[12:0], m_pay[31:0], '0, '0);
            FLG_WR_DIR:   set_cmd(CMD_WR_DIR, m_hdr[12:0], m_pay[31:0], '0, '0);
            FLG_MASK_IDX: set_cmd(CMD_MASK_IDX, m_hdr[12:0], m_pay[31:0], m_pay[63:32], '0);
            FLG_MASK_DIR: set_cmd(CMD_MASK_DIR, m_hdr[12:0], ~m_pay[31:0], m_pay[63:32], '0);
            FLG_DELAY:    set_cmd(CMD_DELAY, '0, '0, '0, m_pay[15:0]);
            default: begin
                if (m_hdr[7:0] == SPC_MC_IDLE) set_cmd(CMD_WAIT_MC, '0, '0, '0, m_pay[15:0]);
                else set_cmd(CMD_WAIT_MEM, '0, '0, '0, m_pay[15:0]);
            end
        endcase
        return OC_CMD;
    endfunction

    // PLL format: one-byte header; write, lane mask or fixed wait
    function automatic t_outcome step_pll(logic [7:0] b);
        logic [1:0] flag;
        logic [5:0] idx;
        logic [7:0] lane;
        int         n;
        int         shift;
        if (m_phase == PH_HDR0) begin
            m_hdr = {8'h00, b};
            if (b == PLL_END) return OC_DONE;
            flag = b[7:6];
            idx  = b[5:0];
            if (flag == PLL_FIXED) begin
                case (idx)
                    PW_DLY_SHORT: set_cmd(CMD_DELAY, '0, '0, '0, WT_SHORT_US);
                    PW_DLY_LONG:  set_cmd(CMD_DELAY, '0, '0, '0, WT_LONG_US);
                    PW_MC_IDLE:   set_cmd(CMD_WAIT_MC, '0, '0, '0, WT_POLL);
                    PW_DLL:       set_cmd(CMD_WAIT_DLL, '0, '0, '0, WT_POLL);
                    PW_POWER:     set_cmd(CMD_POWER, '0, '0, '0, '0);
                    default:      return OC_ERR;
                endcase
                return OC_CMD;
            end
            if (flag != PLL_WR && flag != PLL_MASK) return OC_ERR;
            m_phase = PH_BODY;
            return OC_MORE;
        end
        flag = m_hdr[7:6];
        idx  = m_hdr[5:0];
        n    = collect(b);
        if (flag == PLL_WR) begin
            if (n < 4) return OC_MORE;
            set_cmd(CMD_PLL_WR, IDX_W'(idx), m_pay[31:0], '0, '0);
            return OC_CMD;
        end
        // lane is checked on every body byte, first one included
        lane = m_pay[7:0];
        if (lane > PLL_MAX_LANE) return OC_ERR;
        if (n < 3) return OC_MORE;
        shift = 8 * int'(lane);
        set_cmd(CMD_PLL_MASK, IDX_W'(idx),
                ~(32'hff << shift) | ({24'h0, m_pay[15:8]} << shift),
                {24'h0, m_pay[23:16]} << shift, '0);
        return OC_CMD;
    endfunction

    // SDRAM reset format: code plus 16-bit mode, or memory wait
    function automatic t_outcome step_sdram(logic [7:0] b);
        if (m_phase == PH_HDR0) begin
            m_hdr = {8'h00, b};
            if (b == SDR_END) return OC_DONE;
            if (b == SDR_WAIT) begin
                set_cmd(CMD_WAIT_MEM, '0, '0, '0, WT_SDR_POLL);
                return OC_CMD;
            end
            m_phase = PH_BODY;
            return OC_MORE;
        end
        if (collect(b) < 2) return OC_MORE;
        set_cmd(CMD_SDRAM, IDX_W'(m_hdr[7:0]), '0, {16'h0, m_pay[15:0]}, '0);
        return OC_CMD;
    endfunction

    // Returns the result count in m_out, or -1 when the byte is ignored
    function automatic int decode_script_byte(logic [7:0] b, logic start, logic iend);
        t_outcome oc;
        int       lim;
        if (start) clear_decoder();
        if (m_fin) return -1;
        case (m_fmt)
            FMT_INIT:  oc = step_init(b);
            FMT_PLL:   oc = step_pll(b);
            FMT_SDRAM: oc = step_sdram(b);
            default:   oc = OC_ERR;
        endcase
        if (oc == OC_MORE && iend) oc = OC_ERR;
        if (oc == OC_MORE) return 0;
        if (oc != OC_CMD) begin
            m_fin    = 1'b1;
            m_out[0] = (oc == OC_DONE) ? RES_FIN : RES_ERR;
            return 1;
        end
        m_out[0] = m_cmd;
        clear_entry();
        lim = (m_limit == '0) ? 1 : int'(m_limit);
        if (lim > MAX_ENTRIES) lim = MAX_ENTRIES;
        if (m_seen < 16'hffff) m_seen++;
        if (iend || m_seen >= lim) begin
            m_fin    = 1'b1;
            m_out[1] = RES_ERR;
            return 2;
        end
        return 1;
    endfunction

    function automatic void apply_cfg_write(logic [CFG_IX_W-1:0] ix, logic [CFG_D_W-1:0] d);
        if (ix == CFG_FORMAT) begin
            m_fmt = d[1:0];
            clear_decoder();
        end else if (ix == CFG_LIMIT) begin
            m_limit = d;
        end
    endfunction

    function automatic void note_failure(string msg);
        err_cnt++;
        if (err_cnt <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
    endfunction

    function automatic t_row mk_row(t_row_kind k, logic [7:0] b, logic st, logic ie,
                                    bit typed, t_result res);
        t_row r;
        r.kind  = k;
        r.sbyte = b;
        r.start = st;
        r.iend  = ie;
        r.typed = typed;
        r.res   = res;
        return r;
    endfunction

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hff;
            default: return 8'($urandom);
        endcase
    endfunction

    // Compare one accepted result item with the oldest expectation
    task automatic check_result();
        t_result want;
        results_checked++;
        if (pending_results.size() == 0) begin
            note_failure($sformatf("unexpected result item cmd=%0d idx=%h a=%h b=%h w=%h st=%0d",
                out_if.command, out_if.reg_index, out_if.value_a, out_if.value_b,
                out_if.wait_count, out_if.status));
        end else begin
            want = pending_results.pop_front();
            if (out_if.command !== want.command || out_if.reg_index !== want.reg_index ||
                out_if.value_a !== want.value_a || out_if.value_b !== want.value_b ||
                out_if.wait_count !== want.wait_count || out_if.status !== want.status) begin
                note_failure($sformatf({
                    "mismatch: got cmd=%0d idx=%h a=%h b=%h w=%h st=%0d, ",
                    "want cmd=%0d idx=%h a=%h b=%h w=%h st=%0d"},
                    out_if.command, out_if.reg_index, out_if.value_a, out_if.value_b,
                    out_if.wait_count, out_if.status, want.command, want.reg_index,
                    want.value_a, want.value_b, want.wait_count, want.status));
            end
        end
    endtask

    // Sampling at the rising edge: predict on accepted bytes, check results
    always @(posedge i_clk) begin
        int n;
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                n = decode_script_byte(in_if.script_byte, in_if.starts_script, in_if.image_end);
                all_items++;
                if (n >= 0) live_items++;
                if (cur_typed) pending_results.push_back(cur_res);
                else for (int k = 0; k < n; k++) pending_results.push_back(m_out[k]);
            end
            if (out_if.valid && out_if.ready) check_result();
            if (cfg_if.valid && cfg_if.ready) apply_cfg_write(cfg_if.index, cfg_if.data);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= TIMEOUT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     pending_results.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result side back-pressure
    always @(negedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Called and returning at a falling edge; valid stays high for a following item
    task automatic send_item(logic [7:0] b, logic st, logic ie, bit typed = 1'b0,
                             t_result res = RES_FIN);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid         <= 1'b1;
        in_if.script_byte   <= b;
        in_if.starts_script <= st;
        in_if.image_end     <= ie;
        cur_typed = typed;
        cur_res   = res;
        do @(posedge i_clk); while (!in_if.ready);
        @(negedge i_clk);
    endtask

    // Sender holds off until every expected item is back and the block has settled
    task automatic wait_drained();
        in_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_cfg(logic [CFG_IX_W-1:0] ix, logic [CFG_D_W-1:0] d);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= ix;
        cfg_if.data  <= d;
        do @(posedge i_clk); while (!cfg_if.ready);
        @(negedge i_clk) cfg_if.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // One script entry for the current format: mostly well formed, some noise
    task automatic gen_entry();
        logic [7:0]  bytes [$];
        logic [12:0] idx;
        logic [2:0]  flag;
        logic        start;
        int          r;
        int          n;
        int          end_pct;
        if (m_fin && $urandom_range(99) < 4) begin
            send_item(8'($urandom), 1'b0, 1'($urandom));
            return;
        end
        start   = m_fin || ($urandom_range(99) < 3);
        end_pct = 2;
        r       = $urandom_range(99);
        if (r < 6) begin
            // terminator of the format, image end on it now and then
            end_pct = 25;
            case (m_fmt)
                FMT_INIT: begin
                    bytes.push_back(8'h00);
                    bytes.push_back(8'h00);
                end
                FMT_PLL:   bytes.push_back(PLL_END);
                FMT_SDRAM: bytes.push_back(SDR_END);
                default:   bytes.push_back(rand_byte());
            endcase
        end else if (r < 14) begin
            repeat ($urandom_range(3, 1)) bytes.push_back(8'($urandom));
        end else begin
            case (m_fmt)
                FMT_INIT: begin
                    flag = 3'($urandom_range(FLG_SPECIAL));
                    idx  = 13'($urandom);
                    if (flag == FLG_SPECIAL)
                        idx[7:0] = $urandom_range(1) ? SPC_MC_IDLE : SPC_MEM;
                    bytes.push_back(idx[7:0]);
                    bytes.push_back({flag, idx[12:8]});
                    n = (flag <= FLG_WR_DIR) ? 4 : ((flag <= FLG_MASK_DIR) ? 8 : 2);
                    repeat (n) bytes.push_back(rand_byte());
                end
                FMT_PLL: begin
                    case ($urandom_range(2))
                        0: bytes.push_back({PLL_FIXED, 6'($urandom_range(PW_POWER, PW_DLY_SHORT))});
                        1: begin
                            bytes.push_back({PLL_WR, 6'($urandom)});
                            repeat (4) bytes.push_back(rand_byte());
                        end
                        default: begin
                            bytes.push_back({PLL_MASK, 6'($urandom)});
                            bytes.push_back(8'($urandom_range(PLL_MAX_LANE)));
                            repeat (2) bytes.push_back(rand_byte());
                        end
                    endcase
                end
                FMT_SDRAM: begin
                    if ($urandom_range(3) == 0) begin
                        bytes.push_back(SDR_WAIT);
                    end else begin
                        bytes.push_back(rand_byte());
                        repeat (2) bytes.push_back(rand_byte());
                    end
                end
                default: bytes.push_back(rand_byte());
            endcase
        end
        foreach (bytes[k])
            send_item(bytes[k], (k == 0) ? start : 1'b0, ($urandom_range(99) < end_pct));
    endtask

    // Settings walked by the random part
    logic [1:0] ph_fmt [N_PHASES] = '{FMT_INIT, FMT_PLL, FMT_SDRAM, FMT_INIT,
                                      FMT_PLL, FMT_UNUSED, FMT_SDRAM, FMT_INIT,
                                      FMT_INIT, FMT_PLL, FMT_SDRAM, FMT_INIT};
    int ph_limit [N_PHASES] = '{4096, 4096, 4096, 1, 0, 4096, 8191, 3, 4096, 6, 2, 8191};

    initial begin
        int  target;
        int  mid;
        bit  paused;
        logic [10:0] spare;

        i_rst_n             = 1'b0;
        in_if.valid         = 1'b0;
        in_if.script_byte   = '0;
        in_if.starts_script = 1'b0;
        in_if.image_end     = 1'b0;
        cfg_if.valid        = 1'b0;
        cfg_if.index        = '0;
        cfg_if.data         = '0;
        out_if.ready        = 1'b0;
        cur_typed           = 1'b0;
        cur_res             = RES_FIN;
        m_fmt               = FMT_INIT;
        m_limit             = 13'd4096;
        clear_decoder();
        tx_idle_pct         = 22;
        rx_idle_pct         = 74;
        paused              = 1'b0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // Directed: terminators, bad headers, extremes, image end, format switches
        dir_rows.push_back(mk_row(ROW_BYTE, 8'h00, 1'b1, 1'b0, 1'b0, RES_FIN));
        dir_rows.push_back(mk_row(ROW_BYTE, 8'h00, 1'b0, 1'b0, 1'b1, RES_FIN));
        dir_rows.push_back(mk_row(ROW_BYTE, 8'h5a, 1'b0, 1'b0, 1'b0, RES_FIN));  // ignored
        dir_rows.push_back(mk_row(ROW_BYTE, 8'h07, 1'b1, 1'b0, 1'b0, RES_FIN));
        dir_rows.push_back(mk_row(ROW_BYTE, 8'hc0, 1'b0, 1'b0, 1'b1, RES_ERR));  // bad flag
        dir_rows.push_back(mk_row(ROW_BYTE, 8'h05, 1'b1, 1'b0, 1'b0, RES_FIN));
        dir_rows.push_back(mk_row(ROW_BYTE, 8'ha0, 1'b0, 1'b0, 1'b1, RES_ERR));  // bad special
        dir_rows.push_back(mk_row(ROW_BYTE, 8'hff, 1'b1, 1'b0, 1'b0, RES_FIN));
        dir_rows.push_back(mk_row(ROW_BYTE, 8'h1f, 1'b0, 1'b0, 1'b0, RES_FIN));
        dir_rows.push_back(mk_row(ROW_BYTE, 8'hff, 1'b0, 1'b0, 1'b0, RES_FIN));
        dir_rows.push_back(mk_row(ROW_BYTE, 8'hff, 1'b0, 1'b0, 1'b0, RES_FIN));
        dir_rows.push_back(mk_row(ROW_BYTE, 8'hff, 1'b0, 1'b0, 1'b0, RES_FIN));
        dir_rows.push_back(mk_row(ROW_BYTE, 8'hff, 1'b0, 1'b0, 1'b1, RES_WR_TOP));
        dir_rows.push_back(mk_row(ROW_BYTE, SPC_MC_IDLE, 1'b0, 1'b0, 1'b0, RES_FIN));
        dir_rows.push_back(mk_row(ROW_BYTE, 8'ha0, 1'b0, 1'b0, 1'b0, RES_FIN));
        dir_rows.push_back(mk_row(ROW_BYTE, 8'h34, 1'b0, 1'b0, 1'b0, RES_FIN));
        dir_rows.push_back(mk_row(ROW_BYTE, 8'h12, 1'b0, 1'b0, 1'b0, RES_FIN));
        dir_rows.push_back(mk_row(ROW_BYTE, 8'h00, 1'b0, 1'b0, 1'b0, RES_FIN));
        dir_rows.push_back(mk_row(ROW_BYTE, 8'h80, 1'b0, 1'b1, 1'b1, RES_ERR));  // cut short
        dir_rows.push_back(mk_row(ROW_FMT, {6'h0, FMT_PLL}, 1'b0, 1'b0, 1'b0, RES_FIN));
        dir_rows.push_back(mk_row(ROW_BYTE, PLL_END, 1'b0, 1'b0, 1'b1, RES_FIN));
        dir_rows.push_back(mk_row(ROW_BYTE, {PLL_FIXED, PW_POWER}, 1'b1, 1'b0, 1'b0, RES_FIN));
        dir_rows.push_back(mk_row(ROW_BYTE, {PLL_FIXED, 6'd6}, 1'b0, 1'b0, 1'b1, RES_ERR));
        dir_rows.push_back(mk_row(ROW_BYTE, {PLL_MASK, 6'h00}, 1'b1, 1'b0, 1'b0, RES_FIN));
        dir_rows.push_back(mk_row(ROW_BYTE, 8'h04, 1'b0, 1'b0, 1'b1, RES_ERR));  // lane 4
        dir_rows.push_back(mk_row(ROW_FMT, {6'h0, FMT_SDRAM}, 1'b0, 1'b0, 1'b0, RES_FIN));
        dir_rows.push_back(mk_row(ROW_BYTE, SDR_END, 1'b0, 1'b0, 1'b1, RES_FIN));
        dir_rows.push_back(mk_row(ROW_BYTE, SDR_WAIT, 1'b1, 1'b1, 1'b0, RES_FIN));

        foreach (dir_rows[k]) begin
            if (dir_rows[k].kind == ROW_FMT) begin
                wait_drained();
                write_cfg(CFG_FORMAT, {11'h0, dir_rows[k].sbyte[1:0]});
            end else begin
                send_item(dir_rows[k].sbyte, dir_rows[k].start, dir_rows[k].iend,
                          dir_rows[k].typed, dir_rows[k].res);
            end
        end

        // Random scripts, one setting of format and limit per phase
        for (int p = 0; p < N_PHASES; p++) begin
            wait_drained();
            spare = 11'($urandom);
            write_cfg(CFG_FORMAT, {spare, ph_fmt[p]});
            write_cfg(CFG_LIMIT, 13'(ph_limit[p]));
            if (p == 7) write_cfg(CFG_SPARE, 13'($urandom));
            if (p < 4) begin
                tx_idle_pct = 22;
                rx_idle_pct = 74;
            end else if (p < 8) begin
                tx_idle_pct = 74;
                rx_idle_pct = 22;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            target = live_items + RANDOM_ITEMS / N_PHASES;
            mid    = live_items + RANDOM_ITEMS / (2 * N_PHASES);
            while (live_items < target) begin
                if (p == 1 && !paused && live_items >= mid) begin
                    wait_drained();
                    paused = 1'b1;
                end
                gen_entry();
            end
        end

        wait_drained();
        $display("Sent %0d script bytes (%0d decoded, rest ignored after finish)",
                 all_items, live_items);
        $display("Checked %0d result items over %0d format and limit settings, all formats",
                 results_checked, N_PHASES + 3);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
